@@ rtl/bec_pkg.sv @@
// Package for the blink event classifier: mode and kind codes,
// configuration register indexes, reset values and the configuration bundle.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bec_pkg;

   // Widths fixed by the stream fields.
   localparam int EAR_W   = 16;
   localparam int STAMP_W = 32;
   localparam int MS_W    = 16;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;

   // Eye tracking modes.
   typedef enum logic [1:0] {
      MODE_OPEN    = 2'd0,
      MODE_CLOSING = 2'd1,
      MODE_WAITING = 2'd2
   } mode_type;

   // Reported blink kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_NONE   = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_DOUBLE = 2'd2,
      KIND_LONG   = 2'd3
   } kind_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FIXED_THRESHOLD = 3'd0,
      REG_BASELINE_LEVEL  = 3'd1,
      REG_USE_BASELINE    = 3'd2,
      REG_MIN_CLOSURE     = 3'd3,
      REG_SINGLE_LIMIT    = 3'd4,
      REG_LONG_LIMIT      = 3'd5,
      REG_PAIR_WINDOW     = 3'd6
   } reg_index_type;

   // Reset values of the configuration registers.
   localparam logic [EAR_W-1:0] FIXED_THRESHOLD_RST = 16'd13763;
   localparam logic [EAR_W-1:0] BASELINE_LEVEL_RST  = 16'd0;
   localparam logic [MS_W-1:0]  MIN_CLOSURE_RST     = 16'd50;
   localparam logic [MS_W-1:0]  SINGLE_LIMIT_RST    = 16'd400;
   localparam logic [MS_W-1:0]  LONG_LIMIT_RST      = 16'd1000;
   localparam logic [MS_W-1:0]  PAIR_WINDOW_RST     = 16'd500;

   // Configuration as seen by the classifier.
   typedef struct packed {
      logic [EAR_W-1:0] fixed_threshold;
      logic [EAR_W-1:0] baseline_level;
      logic             use_baseline;
      logic [MS_W-1:0]  min_closure_ms;
      logic [MS_W-1:0]  single_limit_ms;
      logic [MS_W-1:0]  long_limit_ms;
      logic [MS_W-1:0]  pair_window_ms;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/bec_csr.sv @@
// Configuration registers of the blink event classifier.
// Depends on bec_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module bec_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [bec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [bec_pkg::CSR_DATA_W-1:0]    csr_data,
   output bec_pkg::cfg_type                  cfg
);
   import bec_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the written register; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_FIXED_THRESHOLD: cfg_in.fixed_threshold = csr_data;
            REG_BASELINE_LEVEL:  cfg_in.baseline_level  = csr_data;
            REG_USE_BASELINE:    cfg_in.use_baseline    = csr_data[0];
            REG_MIN_CLOSURE:     cfg_in.min_closure_ms  = csr_data;
            REG_SINGLE_LIMIT:    cfg_in.single_limit_ms = csr_data;
            REG_LONG_LIMIT:      cfg_in.long_limit_ms   = csr_data;
            REG_PAIR_WINDOW:     cfg_in.pair_window_ms  = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fixed_threshold <= FIXED_THRESHOLD_RST;
         cfg_ff.baseline_level  <= BASELINE_LEVEL_RST;
         cfg_ff.use_baseline    <= 1'b0;
         cfg_ff.min_closure_ms  <= MIN_CLOSURE_RST;
         cfg_ff.single_limit_ms <= SINGLE_LIMIT_RST;
         cfg_ff.long_limit_ms   <= LONG_LIMIT_RST;
         cfg_ff.pair_window_ms  <= PAIR_WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/bec_fsm.sv @@
// Blink state machine: closed-eye test, duration compares and mode tracking.
// Depends on bec_pkg for mode and kind codes and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module bec_fsm #(
   parameter int TIME_BITS = 32
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           step,
   input  wire  [bec_pkg::EAR_W-1:0]     ear,
   input  wire  [TIME_BITS-1:0]          now,
   input  bec_pkg::cfg_type              cfg,
   output bec_pkg::kind_type             kind
);
   import bec_pkg::*;

   mode_type             mode_ff, mode_in;
   logic [TIME_BITS-1:0] closure_start_ff, closure_start_in;
   logic [TIME_BITS-1:0] short_time_ff, short_time_in;

   logic [EAR_W+3:0]     ear_x10;
   logic [EAR_W+2:0]     base_x7;
   logic                 closed;
   logic [TIME_BITS-1:0] close_dur;
   logic [TIME_BITS-1:0] gap_dur;
   logic                 below_min, at_long, within_single, within_pair;

   // Closed-eye test; 0.7 * baseline is compared as 10 * ear < 7 * baseline.
   always_comb begin
      ear_x10 = {1'b0, ear, 3'b000} + {3'b000, ear, 1'b0};
      base_x7 = {cfg.baseline_level, 3'b000} - {3'b000, cfg.baseline_level};
      if (cfg.use_baseline) begin
         closed = ear_x10 < {1'b0, base_x7};
      end else begin
         closed = ear < cfg.fixed_threshold;
      end
   end

   // Modular durations against the stored timestamps.
   always_comb begin
      close_dur     = now - closure_start_ff;
      gap_dur       = now - short_time_ff;
      below_min     = close_dur <  TIME_BITS'(cfg.min_closure_ms);
      at_long       = close_dur >= TIME_BITS'(cfg.long_limit_ms);
      within_single = close_dur <= TIME_BITS'(cfg.single_limit_ms);
      within_pair   = gap_dur   <= TIME_BITS'(cfg.pair_window_ms);
   end

   // Next mode and reported kind.
   always_comb begin
      mode_in          = mode_ff;
      closure_start_in = closure_start_ff;
      short_time_in    = short_time_ff;
      kind             = KIND_NONE;
      case (mode_ff)
         MODE_CLOSING: begin
            if (!closed) begin
               if (below_min) begin
                  mode_in = MODE_OPEN;
               end else if (at_long) begin
                  mode_in = MODE_OPEN;
                  kind    = KIND_LONG;
               end else if (within_single) begin
                  mode_in       = MODE_WAITING;
                  short_time_in = now;
               end else begin
                  mode_in = MODE_OPEN;
                  kind    = KIND_SINGLE;
               end
            end else if (at_long) begin
               mode_in = MODE_OPEN;
               kind    = KIND_LONG;
            end
         end
         MODE_WAITING: begin
            if (closed) begin
               mode_in          = MODE_CLOSING;
               closure_start_in = now;
               kind             = within_pair ? KIND_DOUBLE : KIND_SINGLE;
            end else if (!within_pair) begin
               mode_in = MODE_OPEN;
               kind    = KIND_SINGLE;
            end
         end
         default: begin
            // Open, and the unused code, which behaves as open.
            mode_in = MODE_OPEN;
            if (closed) begin
               mode_in          = MODE_CLOSING;
               closure_start_in = now;
            end
         end
      endcase
   end

   // State registers advance once per processed sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_OPEN;
         closure_start_ff <= '0;
         short_time_ff    <= '0;
      end else if (step) begin
         mode_ff          <= mode_in;
         closure_start_ff <= closure_start_in;
         short_time_ff    <= short_time_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/blink_event_classifier.sv @@
// Blink event classifier, top level.
// A request is held in the input register; its result is registered for rsp_tdata.
// Throughput: one request per cycle while rsp_tready does not stall the result register.
// Reset (synchronous, active high) restores the register defaults, sets the
// eye mode to open, clears the stored timestamps and empties both stages.
// Depends on bec_pkg, bec_csr and bec_fsm.
`timescale 1ns / 1ps
`default_nettype none

module blink_event_classifier #(
   parameter int TIME_BITS = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   // tdata: ear_sample [15:0], time_ms [47:16]
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [bec_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tdata: blink_kind [1:0], zeros above
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [bec_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [bec_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [bec_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bec_pkg::*;

   cfg_type              cfg;
   kind_type             kind;
   logic                 step;

   logic                 in_valid_ff;
   logic [EAR_W-1:0]     ear_ff;
   logic [STAMP_W-1:0]   stamp_ff;
   logic                 out_valid_ff;
   logic [KIND_W-1:0]    kind_ff;

   bec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bec_fsm #(
      .TIME_BITS (TIME_BITS)
   ) u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .ear   (ear_ff),
      .now   (TIME_BITS'(stamp_ff)),
      .cfg   (cfg),
      .kind  (kind)
   );

   // A held request moves on when the result register is free or draining.
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ear_ff   <= req_tdata[EAR_W-1:0];
         stamp_ff <= req_tdata[EAR_W+STAMP_W-1:EAR_W];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         kind_ff <= kind;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-KIND_W){1'b0}}, kind_ff};

endmodule

`default_nettype wire

@@ sim/blink_event_classifier_tb.sv @@
// Self-checking testbench for blink_event_classifier: EAR samples with timestamps go in,
// and each blink kind that comes out is checked against a local prediction of the classifier.
// Depends on bec_pkg and the RTL of blink_event_classifier.
`timescale 1ns / 1ps

module blink_event_classifier_tb;
   import bec_pkg::*;

   localparam int RESET_CYCLES     = 10;
   localparam int SETTLE_CYCLES    = 6;
   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int SAMPLES_PER_PHASE = 62;
   localparam int LAST_PHASE       = 7;
   // Index past the last register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   typedef struct {
      logic [EAR_W-1:0]   ear;
      logic [STAMP_W-1:0] stamp;
      int                 gap;
   } sample_item;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // Classifier copy: configuration and eye tracking state.
   cfg_type shadow_cfg = '{fixed_threshold: FIXED_THRESHOLD_RST,
                           baseline_level:  BASELINE_LEVEL_RST,
                           use_baseline:    1'b0,
                           min_closure_ms:  MIN_CLOSURE_RST,
                           single_limit_ms: SINGLE_LIMIT_RST,
                           long_limit_ms:   LONG_LIMIT_RST,
                           pair_window_ms:  PAIR_WINDOW_RST};
   mode_type           tracked_mode = MODE_OPEN;
   logic [STAMP_W-1:0] closure_began = '0;
   logic [STAMP_W-1:0] short_blink_end = '0;

   sample_item         pending_samples[$];
   kind_type           expected_kinds[$];
   sample_item         cur_sample;
   logic               req_loaded = 1'b0;
   logic               req_fired = 1'b0;
   int                 req_wait = 0;
   int                 req_calm_left = 0;
   int                 rsp_calm_left = 0;
   int                 rsp_gap_left = 0;
   int                 idle_cycles = 0;
   int                 errors = 0;
   int                 queued_count = 0;
   logic [STAMP_W-1:0] stamp_now = '0;

   blink_event_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the classifier copy by one sample and return the kind it reports.
   function automatic kind_type classify_sample(input logic [EAR_W-1:0] ear,
                                                input logic [STAMP_W-1:0] stamp);
      logic               closed;
      logic [31:0]        ear_scaled;
      logic [31:0]        base_scaled;
      logic [STAMP_W-1:0] span;
      kind_type           kind;
      kind = KIND_NONE;
      // The baseline test 0.7 * baseline is done exactly as 10 * ear < 7 * baseline.
      ear_scaled  = 32'(ear) * 32'd10;
      base_scaled = 32'(shadow_cfg.baseline_level) * 32'd7;
      if (shadow_cfg.use_baseline) begin
         closed = ear_scaled < base_scaled;
      end else begin
         closed = ear < shadow_cfg.fixed_threshold;
      end
      case (tracked_mode)
         MODE_CLOSING: begin
            span = stamp - closure_began;
            if (!closed) begin
               if (span < 32'(shadow_cfg.min_closure_ms)) begin
                  tracked_mode = MODE_OPEN;
               end else if (span >= 32'(shadow_cfg.long_limit_ms)) begin
                  tracked_mode = MODE_OPEN;
                  kind = KIND_LONG;
               end else if (span <= 32'(shadow_cfg.single_limit_ms)) begin
                  tracked_mode = MODE_WAITING;
                  short_blink_end = stamp;
               end else begin
                  tracked_mode = MODE_OPEN;
                  kind = KIND_SINGLE;
               end
            end else if (span >= 32'(shadow_cfg.long_limit_ms)) begin
               tracked_mode = MODE_OPEN;
               kind = KIND_LONG;
            end
         end
         MODE_WAITING: begin
            span = stamp - short_blink_end;
            if (closed) begin
               tracked_mode = MODE_CLOSING;
               closure_began = stamp;
               kind = (span <= 32'(shadow_cfg.pair_window_ms)) ? KIND_DOUBLE : KIND_SINGLE;
            end else if (span > 32'(shadow_cfg.pair_window_ms)) begin
               tracked_mode = MODE_OPEN;
               kind = KIND_SINGLE;
            end
         end
         default: begin
            tracked_mode = MODE_OPEN;
            if (closed) begin
               tracked_mode = MODE_CLOSING;
               closure_began = stamp;
            end
         end
      endcase
      return kind;
   endfunction

   // Stall length for one transfer; now and then a run of transfers without stalls.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // Smallest EAR that reads as open under the current configuration.
   function automatic int open_floor();
      if (shadow_cfg.use_baseline) begin
         return (7 * int'(shadow_cfg.baseline_level) + 9) / 10;
      end
      return int'(shadow_cfg.fixed_threshold);
   endfunction

   function automatic logic [EAR_W-1:0] closed_ear();
      int floor_ear;
      floor_ear = open_floor();
      if (floor_ear == 0) begin
         return 16'($urandom);
      end
      if ($urandom_range(0, 3) == 0) begin
         return 16'(floor_ear - 1);
      end
      return 16'($urandom_range(0, floor_ear - 1));
   endfunction

   function automatic logic [EAR_W-1:0] open_ear();
      int floor_ear;
      floor_ear = open_floor();
      if ($urandom_range(0, 3) == 0) begin
         return 16'(floor_ear);
      end
      return 16'($urandom_range(floor_ear, 65535));
   endfunction

   // Closure lengths cluster on the decision limits.
   function automatic logic [STAMP_W-1:0] pick_duration();
      int unsigned lo_ms;
      int unsigned mid_ms;
      int unsigned hi_ms;
      lo_ms  = shadow_cfg.min_closure_ms;
      mid_ms = shadow_cfg.single_limit_ms;
      hi_ms  = shadow_cfg.long_limit_ms;
      case ($urandom_range(0, 7))
         0: return (lo_ms == 0) ? 32'd0 : 32'(lo_ms - 1);
         1: return 32'(lo_ms);
         2: return 32'(mid_ms);
         3: return 32'(mid_ms + 1);
         4: return (hi_ms == 0) ? 32'd0 : 32'(hi_ms - 1);
         5: return 32'(hi_ms);
         default: return 32'($urandom_range(0, hi_ms + 100));
      endcase
   endfunction

   // Open gaps before a closure cluster on the pair window.
   function automatic logic [STAMP_W-1:0] pick_gap();
      int unsigned window_ms;
      window_ms = shadow_cfg.pair_window_ms;
      case ($urandom_range(0, 5))
         0: return 32'(window_ms);
         1: return 32'(window_ms + 1);
         2: return (window_ms == 0) ? 32'd0 : 32'(window_ms - 1);
         3: return 32'($urandom_range(window_ms + 2, window_ms + 2000));
         default: return 32'($urandom_range(0, window_ms));
      endcase
   endfunction

   task automatic add_sample(input logic [EAR_W-1:0] ear, input logic [STAMP_W-1:0] stamp);
      sample_item item;
      item.ear   = ear;
      item.stamp = stamp;
      item.gap   = draw_gap(req_calm_left);
      pending_samples.push_back(item);
      queued_count++;
   endtask

   // One blink: open frames over the gap, a closure with a few closed frames, then reopening.
   task automatic add_blink(input logic [STAMP_W-1:0] gap);
      int                 fillers;
      int                 holds;
      logic [STAMP_W-1:0] start;
      logic [STAMP_W-1:0] span;
      fillers = (gap > 3) ? $urandom_range(0, 2) : 0;
      for (int i = 1; i <= fillers; i++) begin
         add_sample(open_ear(), stamp_now + 32'((longint'(gap) * i) / (fillers + 1)));
      end
      start = stamp_now + gap;
      span  = pick_duration();
      add_sample(closed_ear(), start);
      holds = (span > 3) ? $urandom_range(0, 3) : 0;
      for (int i = 1; i <= holds; i++) begin
         add_sample(closed_ear(), start + 32'((longint'(span) * i) / (holds + 1)));
      end
      stamp_now = start + span;
      add_sample(open_ear(), stamp_now);
   endtask

   // Mostly well-formed blink trains; the rest are random frames with jumping timestamps.
   task automatic add_random_samples();
      int first_count;
      first_count = queued_count;
      while (queued_count - first_count < SAMPLES_PER_PHASE) begin
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0) begin
                  stamp_now = $urandom;
               end else begin
                  stamp_now = stamp_now + 32'($urandom_range(0, 50));
               end
               add_sample(16'($urandom), stamp_now);
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               add_blink(pick_gap());
            end
         end
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         REG_FIXED_THRESHOLD: shadow_cfg.fixed_threshold = value;
         REG_BASELINE_LEVEL:  shadow_cfg.baseline_level  = value;
         REG_USE_BASELINE:    shadow_cfg.use_baseline    = value[0];
         REG_MIN_CLOSURE:     shadow_cfg.min_closure_ms  = value;
         REG_SINGLE_LIMIT:    shadow_cfg.single_limit_ms = value;
         REG_LONG_LIMIT:      shadow_cfg.long_limit_ms   = value;
         REG_PAIR_WINDOW:     shadow_cfg.pair_window_ms  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Each phase rewrites every register; some phases sit on the extremes.
   task automatic configure_phase(input int phase);
      cfg_type next_cfg;
      next_cfg.fixed_threshold = 16'($urandom);
      next_cfg.baseline_level  = 16'($urandom);
      next_cfg.use_baseline    = 1'b0;
      next_cfg.min_closure_ms  = 16'($urandom_range(0, 100));
      next_cfg.single_limit_ms = 16'($urandom_range(100, 600));
      next_cfg.long_limit_ms   = 16'($urandom_range(600, 2000));
      next_cfg.pair_window_ms  = 16'($urandom_range(0, 1000));
      case (phase)
         2: next_cfg.use_baseline = 1'b1;
         3: begin
            next_cfg.fixed_threshold = 16'hFFFF;
            next_cfg.min_closure_ms  = 16'd0;
            next_cfg.single_limit_ms = 16'd0;
            next_cfg.long_limit_ms   = 16'd0;
            next_cfg.pair_window_ms  = 16'd0;
         end
         4: begin
            next_cfg.use_baseline    = 1'b1;
            next_cfg.baseline_level  = 16'hFFFF;
            next_cfg.min_closure_ms  = 16'hFFFF;
            next_cfg.single_limit_ms = 16'hFFFF;
            next_cfg.long_limit_ms   = 16'hFFFF;
            next_cfg.pair_window_ms  = 16'hFFFF;
         end
         5: begin
            // No sample can read as closed.
            next_cfg.use_baseline   = 1'b1;
            next_cfg.baseline_level = 16'd0;
         end
         6: begin
            // Limits in any order, also inconsistent ones.
            next_cfg.use_baseline    = 1'($urandom_range(0, 1));
            next_cfg.min_closure_ms  = 16'($urandom);
            next_cfg.single_limit_ms = 16'($urandom);
            next_cfg.long_limit_ms   = 16'($urandom);
            next_cfg.pair_window_ms  = 16'($urandom);
         end
         7: next_cfg.fixed_threshold = 16'd1;
         default: ;
      endcase
      write_register(REG_FIXED_THRESHOLD, next_cfg.fixed_threshold);
      write_register(REG_BASELINE_LEVEL, next_cfg.baseline_level);
      write_register(REG_USE_BASELINE, {15'($urandom), next_cfg.use_baseline});
      write_register(REG_MIN_CLOSURE, next_cfg.min_closure_ms);
      write_register(REG_SINGLE_LIMIT, next_cfg.single_limit_ms);
      write_register(REG_LONG_LIMIT, next_cfg.long_limit_ms);
      write_register(REG_PAIR_WINDOW, next_cfg.pair_window_ms);
      if (phase == 1) begin
         write_register(REG_SPARE, 16'($urandom));
      end
   endtask

   // Wait until every queued request has been answered and the pipeline is quiet.
   task automatic drain();
      while (pending_samples.size() != 0 || req_loaded || expected_kinds.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: presents queued samples after their idle gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_fired) begin
            req_fired  = 1'b0;
            req_loaded = 1'b0;
         end
         if (!req_loaded && pending_samples.size() != 0) begin
            cur_sample = pending_samples.pop_front();
            req_loaded = 1'b1;
            req_wait   = cur_sample.gap;
         end
         if (req_loaded && req_wait == 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {cur_sample.stamp, cur_sample.ear};
         end else begin
            req_tvalid <= 1'b0;
            if (req_loaded) begin
               req_wait--;
            end
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      if (rsp_gap_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_gap_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: checks results against the oldest prediction, predicts accepted requests.
   always @(posedge clock) begin
      kind_type want;
      if (!reset) begin
         idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            if (expected_kinds.size() == 0) begin
               $display("%0t: result %h with no request outstanding", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_kinds.pop_front();
               if (rsp_tdata !== {{(RSP_DATA_W - KIND_W){1'b0}}, want}) begin
                  $display("%0t: blink_kind expected %s (%h), got %h", $time, want.name(),
                           {{(RSP_DATA_W - KIND_W){1'b0}}, want}, rsp_tdata);
                  errors++;
               end
            end
            rsp_gap_left = draw_gap(rsp_calm_left);
         end
         if (req_tvalid && req_tready) begin
            idle_cycles = 0;
            expected_kinds.push_back(classify_sample(req_tdata[EAR_W-1:0],
                                                     req_tdata[EAR_W +: STAMP_W]));
            req_fired = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            idle_cycles = 0;
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("blink_event_classifier test failed");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk through every decision with the reset configuration.
      add_sample(16'hFFFF, 32'd0);
      add_sample(16'h0000, 32'd10);        // closure starts
      add_sample(16'hFFFF, 32'd30);        // too short, rejected as noise
      add_sample(16'd13762, 32'd100);      // just under the threshold
      add_sample(16'd13763, 32'd300);      // at the threshold reads open: short blink
      add_sample(16'h0000, 32'd700);       // second blink inside the window: double
      add_sample(16'hFFFF, 32'd1700);      // reopens at the long limit: long
      add_sample(16'h0000, 32'd2000);
      add_sample(16'h0000, 32'd3000);      // still closed at the long limit: long
      add_sample(16'h0000, 32'd3000);
      add_sample(16'd40000, 32'd3500);     // between the single and long limits: single
      add_sample(16'h0000, 32'd4000);
      add_sample(16'd40000, 32'd4050);     // exactly the noise limit: waits for a pair
      add_sample(16'd40000, 32'd4550);     // gap equals the window: nothing yet
      add_sample(16'd40000, 32'd4551);     // window passed: single
      add_sample(16'd100, 32'hFFFF_FF00);
      add_sample(16'hFFFF, 32'h0000_0040); // duration across the timestamp wrap
      add_sample(16'h0000, 32'h0000_0300); // second blink too late: single
      add_sample(16'hFFFF, 32'h0000_0200); // time runs backwards: long
      add_sample(16'h0000, 32'hFFFF_FFFF);
      add_sample(16'h0000, 32'h0000_0000);
      add_sample(16'hFFFF, 32'h0000_0100); // waits for a pair
      add_sample(16'hFFFF, 32'hFFFF_FFFF); // backwards gap exceeds the window: single
      stamp_now = 32'hFFFF_FFFF;
      add_random_samples();
      drain();

      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         configure_phase(phase);
         add_random_samples();
         drain();
      end

      if (errors == 0 && expected_kinds.size() == 0) begin
         $display("blink_event_classifier test passed");
      end else begin
         $display("blink_event_classifier test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bec_pkg.sv
rtl/bec_csr.sv
rtl/bec_fsm.sv
rtl/blink_event_classifier.sv
sim/blink_event_classifier_tb.sv
